// File: hw/rtl/echo_median_range_filter_defines.svh
// Assertion macros for the echo median range filter.
`ifndef ECHO_MEDIAN_RANGE_FILTER_DEFINES_SVH
`define ECHO_MEDIAN_RANGE_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define EMRF_ASSERT_CR(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EMRF_ASSERT(label, prop, msg) `EMRF_ASSERT_CR(label, clk_i, rst_ni, prop, msg)
`else
`define EMRF_ASSERT_CR(label, clk, rst_n, prop, msg)
`define EMRF_ASSERT(label, prop, msg)
`endif

`endif

// File: hw/rtl/emrf_pkg.sv
package emrf_pkg;

  localparam int unsigned EchoW         = 15;
  localparam int unsigned DistW         = 16;
  localparam int unsigned CfgW          = 4;
  localparam int unsigned DefMaxSamples = 8;

  localparam logic [CfgW-1:0] CfgReset = 4'd5;

  // ceil(343 * 2^24 / 200): exact floor(us * 343 / 200) for any 15-bit us
  localparam int unsigned DistMulW  = 25;
  localparam int unsigned DistShift = 24;
  localparam logic [DistMulW-1:0] DistMul = 25'd28772926;

  typedef struct packed {
    logic take;
    logic rd_prev;
    logic shift;
    logic place;
    logic load;
  } emrf_cmd_t;

  typedef struct packed {
    logic need_ins;
    logic burst_end;
    logic ends_burst;
    logic j_zero;
    logic gt;
    logic out_free;
  } emrf_status_t;

endpackage

// File: hw/rtl/emrf_in_if.sv
interface emrf_in_if;
  import emrf_pkg::*;

  logic             valid;
  logic             ready;
  logic [EchoW-1:0] echo_us;

  modport source (output valid, output echo_us, input ready);
  modport sink   (input valid, input echo_us, output ready);
endinterface

// File: hw/rtl/emrf_out_if.sv
interface emrf_out_if;
  import emrf_pkg::*;

  logic             valid;
  logic             ready;
  logic [DistW-1:0] distance_hundredths_cm;
  logic [EchoW-1:0] median_echo_us;
  logic             found;

  modport source (output valid, output distance_hundredths_cm, output median_echo_us,
                  output found, input ready);
  modport sink   (input valid, input distance_hundredths_cm, input median_echo_us,
                  input found, output ready);
endinterface

// File: hw/rtl/emrf_ram.sv
module emrf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: hw/rtl/emrf_ctrl.sv
`include "echo_median_range_filter_defines.svh"

module emrf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  emrf_pkg::emrf_status_t status_i,
  output emrf_pkg::emrf_cmd_t    cmd_o
);
  import emrf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_CMP  = 5'b00100,
    S_MED  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (status_i.need_ins) begin
            state_d = S_READ;
          end else if (status_i.burst_end) begin
            state_d = S_MED;
          end
        end
      end
      S_READ: begin
        if (status_i.j_zero) begin
          cmd_o.place = 1'b1;
          state_d     = status_i.ends_burst ? S_MED : S_IDLE;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = S_CMP;
        end
      end
      S_CMP: begin
        if (status_i.gt) begin
          cmd_o.shift = 1'b1;
          state_d     = S_READ;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = status_i.ends_burst ? S_MED : S_IDLE;
        end
      end
      S_MED: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `EMRF_ASSERT(a_timeout_mid_burst_quick, cmd_o.take && !status_i.need_ins && !status_i.burst_end |=> in_ready_o, "timeout word inside a burst did not return to idle")
  `EMRF_ASSERT(a_load_frees_input, cmd_o.load |=> in_ready_o, "input not reopened after result load")
  `EMRF_ASSERT(a_state_onehot, $onehot(state_q), "controller state not one-hot")

endmodule

// File: hw/rtl/emrf_datapath.sv
`include "echo_median_range_filter_defines.svh"

module emrf_datapath #(
  parameter int unsigned MaxSamples = emrf_pkg::DefMaxSamples
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [emrf_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic [emrf_pkg::EchoW-1:0]   echo_us_i,
  input  emrf_pkg::emrf_cmd_t          cmd_i,
  output emrf_pkg::emrf_status_t       status_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [emrf_pkg::DistW-1:0]   distance_o,
  output logic [emrf_pkg::EchoW-1:0]   median_o,
  output logic                         found_o
);
  import emrf_pkg::*;

  localparam int unsigned IdxW  = (MaxSamples > 1) ? $clog2(MaxSamples) : 1;
  localparam int unsigned CntW  = $clog2(MaxSamples + 1);
  localparam int unsigned LenW  = (CntW > CfgW) ? CntW : CfgW;
  localparam int unsigned ProdW = EchoW + DistMulW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxSamples);

  logic [CfgW-1:0]  sample_count_q;
  logic [CntW-1:0]  valid_cnt_q, taken_cnt_q, taken_nx;
  logic [EchoW-1:0] v_q;
  logic [IdxW-1:0]  j_q;
  logic             end_q;
  logic             out_valid_q;
  logic [DistW-1:0] dist_q;
  logic [EchoW-1:0] med_q;
  logic             found_q;

  logic [LenW-1:0]  cfg_ext, burst_len;
  logic             need_ins;
  logic [IdxW-1:0]  med_idx, raddr;
  logic [EchoW-1:0] rdata, wdata;
  logic [ProdW-1:0] prod;

  assign cfg_ext   = LenW'(sample_count_q);
  assign burst_len = (cfg_ext == '0) ? LenW'(1) :
                     (cfg_ext > LenW'(MaxSamples)) ? LenW'(MaxSamples) : cfg_ext;
  assign taken_nx  = (taken_cnt_q < MaxCnt) ? taken_cnt_q + CntW'(1) : taken_cnt_q;
  assign need_ins  = (echo_us_i != '0) && (valid_cnt_q < MaxCnt);
  assign med_idx   = IdxW'(valid_cnt_q >> 1);
  assign raddr     = cmd_i.rd_prev ? j_q - IdxW'(1) : med_idx;
  assign wdata     = cmd_i.shift ? rdata : v_q;
  assign prod      = ProdW'(rdata) * ProdW'(DistMul);

  assign status_o.need_ins   = need_ins;
  assign status_o.burst_end  = LenW'(taken_nx) >= burst_len;
  assign status_o.ends_burst = end_q;
  assign status_o.j_zero     = (j_q == '0);
  assign status_o.gt         = rdata > v_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  emrf_ram #(
    .Width (EchoW),
    .Depth (MaxSamples)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.shift || cmd_i.place),
    .waddr_i (j_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= CfgReset;
      valid_cnt_q    <= '0;
      taken_cnt_q    <= '0;
      end_q          <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sample_count_q <= cfg_wdata_i;
      end
      if (cmd_i.take) begin
        taken_cnt_q <= taken_nx;
        end_q       <= status_o.burst_end;
        if (need_ins) begin
          valid_cnt_q <= valid_cnt_q + CntW'(1);
        end
      end
      if (cmd_i.load) begin
        valid_cnt_q <= '0;
        taken_cnt_q <= '0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      v_q <= echo_us_i;
      j_q <= IdxW'(valid_cnt_q);
    end else if (cmd_i.shift) begin
      j_q <= j_q - IdxW'(1);
    end
    if (cmd_i.load) begin
      found_q <= (valid_cnt_q != '0);
      med_q   <= (valid_cnt_q != '0) ? rdata : '0;
      dist_q  <= (valid_cnt_q != '0) ? prod[DistShift +: DistW] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;
  assign median_o    = med_q;
  assign found_o     = found_q;

  `EMRF_ASSERT(a_valid_le_taken, valid_cnt_q <= taken_cnt_q, "more stored words than taken words")
  `EMRF_ASSERT(a_load_restarts, cmd_i.load |=> (valid_cnt_q == '0) && (taken_cnt_q == '0) && out_valid_q, "burst not restarted on result load")
  `EMRF_ASSERT(a_not_found_zero, out_valid_q && !found_q |-> (dist_q == '0) && (med_q == '0), "not-found result carries data")

endmodule

// File: hw/rtl/echo_median_range_filter.sv
// Channel    Dir  Payload                                          Handshake
// echo_i     in   echo_us[14:0]                                    valid/ready
// result_o   out  distance_hundredths_cm[15:0], median_echo_us,    valid/ready
//                 found
// cfg        in   cfg_wdata_i[3:0] (sample_count)                  cfg_we_i
//
// A timeout word (echo_us of 0) is taken in idle. A stored word runs the
// insertion loop: read, compare, and move each larger sorted entry up, then
// write the word in its place, on a sample store with one read port and one
// write port. A burst end adds the median read, plus any wait while the
// result register is still held by a stalled sink.
// Reset clears counters and control only; no clearing pass.
module echo_median_range_filter #(
  parameter int unsigned MaxSamples = emrf_pkg::DefMaxSamples
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [emrf_pkg::CfgW-1:0] cfg_wdata_i,
  emrf_in_if.sink                   echo_i,
  emrf_out_if.source                result_o
);
  import emrf_pkg::*;

  emrf_cmd_t    cmd;
  emrf_status_t status;

  emrf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (echo_i.valid),
    .in_ready_o (echo_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  emrf_datapath #(
    .MaxSamples (MaxSamples)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .echo_us_i   (echo_i.echo_us),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .distance_o  (result_o.distance_hundredths_cm),
    .median_o    (result_o.median_echo_us),
    .found_o     (result_o.found)
  );

endmodule

// File: verif/echo_median_range_filter_tb.sv
`timescale 1ns / 100ps
module echo_median_range_filter_tb;
  import emrf_pkg::*;

  localparam int unsigned StoreDepth   = DefMaxSamples;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned RandomWords  = 550;

  typedef struct packed {
    logic [DistW-1:0] dist_cm;
    logic [EchoW-1:0] med;
    logic             found;
  } range_t;

  logic            clk_i     = 1'b0;
  logic            rst_ni    = 1'b1;
  logic            cfg_we    = 1'b0;
  logic [CfgW-1:0] cfg_wdata = '0;

  emrf_in_if  echo_if ();
  emrf_out_if result_if ();

  echo_median_range_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .echo_i      (echo_if),
    .result_o    (result_if)
  );

  always #10 clk_i = ~clk_i;

  logic [EchoW-1:0] echo_queue[$];
  logic [EchoW-1:0] phase_words[$];
  range_t           range_queue[$];

  // predictor state
  logic [EchoW-1:0] burst_widths[$];
  int unsigned      burst_taken;
  logic [CfgW-1:0]  count_shadow;
  range_t           want_r;
  int unsigned      mismatch_count = 0;

  function automatic void take_echo(logic [EchoW-1:0] us);
    logic [EchoW-1:0] sorted[$];
    int unsigned      len;
    int unsigned      med;
    range_t           r;
    if (us != '0 && burst_widths.size() < StoreDepth) burst_widths.push_back(us);
    if (burst_taken < StoreDepth) burst_taken++;
    len = (count_shadow == '0) ? 1 : ((count_shadow > StoreDepth) ? StoreDepth : count_shadow);
    if (burst_taken < len) return;
    r = '0;
    if (burst_widths.size() != 0) begin
      sorted = burst_widths;
      sorted.sort();
      med       = sorted[sorted.size() / 2];
      r.dist_cm = DistW'((med * 343) / 200);
      r.med     = EchoW'(med);
      r.found   = 1'b1;
    end
    range_queue.push_back(r);
    burst_widths.delete();
    burst_taken = 0;
  endfunction

  // driver: bursts of words with random gaps
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_if.valid   <= 1'b0;
      echo_if.echo_us <= '0;
      burst_left      <= 0;
      gap_left        <= 0;
    end else if (!echo_if.valid || echo_if.ready) begin
      if (gap_left != 0) begin
        gap_left      <= gap_left - 1;
        echo_if.valid <= 1'b0;
      end else if (echo_queue.size() != 0) begin
        echo_if.valid   <= 1'b1;
        echo_if.echo_us <= echo_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        echo_if.valid <= 1'b0;
      end
    end
  end

  // sink stall pattern: modes of always ready, coin flip, long holds
  int unsigned ready_mode;
  int unsigned mode_left;
  int unsigned hold_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      ready_mode      <= 0;
      mode_left       <= 0;
      hold_left       <= 0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(32, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0: result_if.ready <= 1'b1;
        1: result_if.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            result_if.ready <= 1'b0;
          end else begin
            result_if.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) hold_left <= $urandom_range(1, 25);
          end
        end
      endcase
    end
  end

  // monitor: predict on accepted echo words, check accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_shadow = CfgReset;
      burst_widths.delete();
      burst_taken = 0;
    end else begin
      if (cfg_we) count_shadow = cfg_wdata;
      if (echo_if.valid && echo_if.ready) take_echo(echo_if.echo_us);
      if (result_if.valid && result_if.ready) begin
        if (range_queue.size() == 0) begin
          $error("result word with no expectation pending");
          mismatch_count++;
        end else begin
          want_r = range_queue.pop_front();
          if (result_if.distance_hundredths_cm !== want_r.dist_cm) begin
            $error("distance_hundredths_cm: expected %0d, got %0d",
                   want_r.dist_cm, result_if.distance_hundredths_cm);
            mismatch_count++;
          end
          if (result_if.median_echo_us !== want_r.med) begin
            $error("median_echo_us: expected %0d, got %0d",
                   want_r.med, result_if.median_echo_us);
            mismatch_count++;
          end
          if (result_if.found !== want_r.found) begin
            $error("found: expected %0d, got %0d", want_r.found, result_if.found);
            mismatch_count++;
          end
        end
      end
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (echo_if.valid && echo_if.ready) ||
        (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("echo_median_range_filter verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drain();
    while (echo_queue.size() != 0 || echo_if.valid || range_queue.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [CfgW-1:0] count);
    drain();
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
    foreach (phase_words[i]) echo_queue.push_back(phase_words[i]);
  endtask

  initial begin
    int unsigned      sent;
    int unsigned      n;
    logic [EchoW-1:0] w;
    logic [CfgW-1:0]  count;
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset count of 5: all timeouts, then extremes with one timeout
    echo_queue = '{15'd0, 15'd0, 15'd0, 15'd0, 15'd0,
                   15'h7FFF, 15'd1, 15'd30000, 15'h4000, 15'd0};
    phase_words = '{15'd1, 15'd0};
    run_phase(4'd1);
    phase_words = '{15'h7FFF};
    run_phase(4'd0);
    phase_words = '{15'h2AAA, 15'h5555, 15'd3, 15'd0, 15'd30001,
                    15'd12, 15'd12, 15'd29999};
    run_phase(4'd15);
    // partial burst, then shrink the count below what was already taken
    phase_words = '{15'd400, 15'd0, 15'd7};
    run_phase(4'd8);
    phase_words = '{15'd900};
    run_phase(4'd2);

    sent = 0;
    while (sent < RandomWords) begin
      n = $urandom_range(8, 60);
      phase_words.delete();
      repeat (n) begin
        case ($urandom_range(0, 9))
          0, 1:    w = '0;
          2:       w = EchoW'($urandom_range(30001, 32767));
          3:       w = EchoW'($urandom_range(1, 16));
          4:       w = EchoW'(1) << $urandom_range(0, 14);
          default: w = EchoW'($urandom_range(1, 30000));
        endcase
        phase_words.push_back(w);
      end
      case ($urandom_range(0, 5))
        0:       count = '0;
        1:       count = '1;
        2:       count = CfgW'($urandom_range(9, 14));
        default: count = CfgW'($urandom_range(1, 8));
      endcase
      run_phase(count);
      sent += n;
    end

    drain();
    if (mismatch_count == 0) begin
      $display("echo_median_range_filter verification clean");
    end else begin
      $display("echo_median_range_filter verification failed");
    end
    $finish;
  end

endmodule
